// File: hw/rtl/lbm_pkg.sv
package lbm_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int BAND_W      = 3;
    localparam int GAIN_W      = 12;
    localparam int PEAK_W      = 12;
    localparam int COLOR_W     = 8;
    localparam int INDEX_W     = 8;
    // signed strip position, holds every bound the bar can produce
    localparam int POS_W       = 8;
    localparam int LEVEL_SHIFT = 28;
    localparam int K_PEAK_BASE = 364;
    localparam int K_OLD       = 79 * 4096;

    localparam logic [SAMPLE_W-1:0] MID_SCALE  = 12'd2048;
    localparam logic [GAIN_W-1:0]   GAIN_RESET = 12'd256;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_UPDATE = 1'b1
    } op_t;

    typedef struct packed {
        op_t                 operation;
        logic [BAND_W-1:0]   band;
        logic [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] pixel_index;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               last;
    } pixel_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic [PEAK_W-1:0] peak;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

    typedef struct packed {
        logic busy;
    } back_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CALC,
        BK_SCALE,
        BK_CLAMP,
        BK_PLAN,
        BK_UPPER,
        BK_LOWER
    } back_state_t;

    // fixed color per strip; dim is the lower-side tenth of each component
    function automatic rgb_t strip_color(input logic [3:0] strip, input logic dim);
        rgb_t c;
        case (strip)
            4'd0:    c = dim ? rgb_t'{8'd25, 8'd0, 8'd0}  : rgb_t'{8'd255, 8'd0, 8'd0};
            4'd1:    c = dim ? rgb_t'{8'd20, 8'd0, 8'd5}  : rgb_t'{8'd200, 8'd0, 8'd55};
            4'd2:    c = dim ? rgb_t'{8'd14, 8'd0, 8'd11} : rgb_t'{8'd145, 8'd0, 8'd110};
            4'd3:    c = dim ? rgb_t'{8'd9, 8'd0, 8'd16}  : rgb_t'{8'd90, 8'd0, 8'd165};
            4'd4:    c = dim ? rgb_t'{8'd3, 8'd0, 8'd22}  : rgb_t'{8'd35, 8'd0, 8'd220};
            4'd5:    c = dim ? rgb_t'{8'd0, 8'd0, 8'd25}  : rgb_t'{8'd0, 8'd0, 8'd255};
            4'd6:    c = dim ? rgb_t'{8'd0, 8'd3, 8'd22}  : rgb_t'{8'd0, 8'd35, 8'd220};
            4'd7:    c = dim ? rgb_t'{8'd0, 8'd7, 8'd18}  : rgb_t'{8'd0, 8'd70, 8'd185};
            4'd8:    c = dim ? rgb_t'{8'd0, 8'd10, 8'd15} : rgb_t'{8'd0, 8'd105, 8'd150};
            4'd9:    c = dim ? rgb_t'{8'd0, 8'd14, 8'd11} : rgb_t'{8'd0, 8'd140, 8'd115};
            4'd10:   c = dim ? rgb_t'{8'd0, 8'd17, 8'd8}  : rgb_t'{8'd0, 8'd175, 8'd80};
            4'd11:   c = dim ? rgb_t'{8'd0, 8'd21, 8'd4}  : rgb_t'{8'd0, 8'd210, 8'd45};
            4'd12:   c = dim ? rgb_t'{8'd0, 8'd24, 8'd1}  : rgb_t'{8'd0, 8'd245, 8'd10};
            4'd13:   c = dim ? rgb_t'{8'd0, 8'd25, 8'd0}  : rgb_t'{8'd0, 8'd255, 8'd0};
            default: c = dim ? rgb_t'{8'd25, 8'd0, 8'd0}  : rgb_t'{8'd255, 8'd0, 8'd0};
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/lbm_fifo.sv
module lbm_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lbm_pkg::q_entry_t      wdata,
    input  logic                   pop,
    output lbm_pkg::q_entry_t      rdata,
    output lbm_pkg::fifo_status_t  status
);
    import lbm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t           slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign rdata        = slot_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/lbm_front.sv
module lbm_front #(
    parameter int BANDS = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  lbm_pkg::item_t     item,
    output logic               q_push,
    output lbm_pkg::q_entry_t  q_entry,
    input  logic               q_full
);
    import lbm_pkg::*;

    localparam int BIDX_W = (BANDS > 1) ? $clog2(BANDS) : 1;

    logic [PEAK_W-1:0]   peak_reg [BANDS];
    logic [BIDX_W-1:0]   idx;
    logic                in_range;
    logic                accept;
    logic [SAMPLE_W-1:0] mag;

    assign idx      = BIDX_W'(item.band);
    assign in_range = (int'(item.band) < BANDS);
    // samples never need queue space
    assign item_ready = !q_full || (item.operation == OP_SAMPLE);
    assign accept     = item_valid && item_ready;
    assign mag        = (item.sample >= MID_SCALE) ? item.sample - MID_SCALE
                                                   : MID_SCALE - item.sample;

    assign q_push       = accept && in_range && (item.operation == OP_UPDATE);
    assign q_entry.band = item.band;
    assign q_entry.peak = peak_reg[idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BANDS; i++)
            begin
                peak_reg[i] <= '0;
            end
        end
        else if (accept && in_range)
        begin
            if (item.operation == OP_UPDATE)
            begin
                peak_reg[idx] <= '0;
            end
            else if (PEAK_W'(mag) > peak_reg[idx])
            begin
                peak_reg[idx] <= PEAK_W'(mag);
            end
        end
    end

endmodule

// File: hw/rtl/lbm_back.sv
module lbm_back #(
    parameter int BANDS     = 7,
    parameter int STRIP_LEN = 16,
    parameter int CENTER    = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lbm_pkg::GAIN_W-1:0]    cfg_wdata,
    input  lbm_pkg::q_entry_t             q_entry,
    input  lbm_pkg::fifo_status_t         q_status,
    output logic                          q_pop,
    output logic                          pixel_valid,
    input  logic                          pixel_ready,
    output lbm_pkg::pixel_t               pixel,
    output lbm_pkg::back_status_t         status
);
    import lbm_pkg::*;

    localparam int SPAN    = (STRIP_LEN > CENTER) ? STRIP_LEN - CENTER : 0;
    localparam int LVL_W   = (SPAN > 1) ? $clog2(SPAN + 1) : 1;
    localparam int BIDX_W  = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int K_PEAK  = K_PEAK_BASE * SPAN;
    localparam int ACC_MAX = K_PEAK * 4095 + K_OLD * SPAN;
    localparam int ACC_W   = ($clog2(ACC_MAX + 1) > 20) ? $clog2(ACC_MAX + 1) : 20;
    localparam int PROD_W  = ACC_W + GAIN_W;

    localparam logic signed [POS_W-1:0] C_POS   = POS_W'(CENTER);
    localparam logic signed [POS_W-1:0] TOP_POS = POS_W'(STRIP_LEN - 1);
    localparam logic signed [POS_W-1:0] P_ONE   = 1;
    localparam logic signed [POS_W-1:0] P_ZERO  = 0;

    back_state_t         state_reg, state_next;
    logic [GAIN_W-1:0]   gain_reg;
    logic [LVL_W-1:0]    bar_reg [BANDS];
    logic [BAND_W-1:0]   band_reg;
    logic [PEAK_W-1:0]   peak_reg;
    logic [LVL_W-1:0]    old_reg;
    logic [LVL_W-1:0]    newl_reg;
    logic                grow_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic signed [POS_W-1:0] pos_reg, up_last_reg, lo_first_reg, lo_last_reg;
    logic                lo_any_reg;
    logic                sel_reg;
    pixel_t              pixel_reg;
    logic                pixel_valid_reg;

    logic [BIDX_W-1:0]   bidx;
    logic [PROD_W-1:0]   shifted;
    logic [LVL_W-1:0]    clamp_lvl;
    logic signed [POS_W-1:0] a_s, b_s, shr_s;
    logic signed [POS_W-1:0] up_first, up_last_raw, up_last, lo_first, lo_last_raw, lo_last;
    logic                up_any, lo_any;
    logic                out_free;
    logic                emit, emit_last, seg_end;
    logic [15:0]         idx_wide;
    rgb_t                color;

    assign bidx     = BIDX_W'(band_reg);
    assign out_free = !pixel_valid_reg || pixel_ready;

    // level from the product, clamped to the span
    assign shifted   = prod_reg >> LEVEL_SHIFT;
    assign clamp_lvl = (shifted > PROD_W'(SPAN)) ? LVL_W'(SPAN) : shifted[LVL_W-1:0];

    // pixel ranges between old and new bar, clipped to the strip
    always_comb
    begin
        a_s         = POS_W'(grow_reg ? old_reg : newl_reg);
        b_s         = POS_W'(grow_reg ? newl_reg : old_reg);
        shr_s       = grow_reg ? P_ZERO : P_ONE;
        up_first    = C_POS + a_s + shr_s;
        up_last_raw = C_POS + b_s;
        up_last     = (up_last_raw > TOP_POS) ? TOP_POS : up_last_raw;
        lo_first    = C_POS - a_s - P_ONE - shr_s;
        lo_last_raw = C_POS - b_s - P_ONE;
        lo_last     = (lo_last_raw < P_ZERO) ? P_ZERO : lo_last_raw;
        up_any      = (up_first <= up_last);
        lo_any      = (lo_first >= lo_last);
    end

    always_comb
    begin
        if (state_reg == BK_UPPER)
        begin
            seg_end = (pos_reg == up_last_reg);
        end
        else
        begin
            seg_end = (pos_reg == lo_last_reg);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = BK_CALC;
                end
            end
            BK_CALC:  state_next = BK_SCALE;
            BK_SCALE: state_next = BK_CLAMP;
            BK_CLAMP: state_next = BK_PLAN;
            BK_PLAN:
            begin
                if (up_any)
                begin
                    state_next = BK_UPPER;
                end
                else if (lo_any)
                begin
                    state_next = BK_LOWER;
                end
                else
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_UPPER:
            begin
                if (out_free && sel_reg && seg_end)
                begin
                    state_next = lo_any_reg ? BK_LOWER : BK_IDLE;
                end
            end
            BK_LOWER:
            begin
                if (out_free && sel_reg && seg_end)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        q_pop     = 1'b0;
        emit      = 1'b0;
        emit_last = 1'b0;
        case (state_reg)
            BK_IDLE:  q_pop = !q_status.empty;
            BK_UPPER:
            begin
                emit      = out_free;
                emit_last = sel_reg && seg_end && !lo_any_reg;
            end
            BK_LOWER:
            begin
                emit      = out_free;
                emit_last = sel_reg && seg_end;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // strip number is 2*band + sel
    assign idx_wide = 16'({band_reg, sel_reg}) * 16'(STRIP_LEN) + 16'($unsigned(pos_reg));
    assign color    = grow_reg ? strip_color({band_reg, sel_reg}, pos_reg < C_POS) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            gain_reg        <= GAIN_RESET;
            pixel_valid_reg <= 1'b0;
            for (int i = 0; i < BANDS; i++)
            begin
                bar_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                gain_reg <= cfg_wdata;
            end
            if (state_reg == BK_CLAMP)
            begin
                bar_reg[bidx] <= clamp_lvl;
            end
            if (emit)
            begin
                pixel_valid_reg <= 1'b1;
            end
            else if (pixel_ready)
            begin
                pixel_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                band_reg <= q_entry.band;
                peak_reg <= q_entry.peak;
            end
            BK_CALC:
            begin
                old_reg <= bar_reg[bidx];
                acc_reg <= ACC_W'(ACC_W'(peak_reg) * ACC_W'(K_PEAK))
                         + ACC_W'(ACC_W'(bar_reg[bidx]) * ACC_W'(K_OLD));
            end
            BK_SCALE:
            begin
                prod_reg <= PROD_W'(acc_reg) * PROD_W'(gain_reg);
            end
            BK_CLAMP:
            begin
                newl_reg <= clamp_lvl;
                grow_reg <= (clamp_lvl > old_reg);
            end
            BK_PLAN:
            begin
                up_last_reg  <= up_last;
                lo_first_reg <= lo_first;
                lo_last_reg  <= lo_last;
                lo_any_reg   <= lo_any;
                pos_reg      <= up_any ? up_first : lo_first;
                sel_reg      <= 1'b0;
            end
            default:
            begin
                if (emit)
                begin
                    sel_reg <= !sel_reg;
                    if (sel_reg)
                    begin
                        if (state_reg == BK_UPPER)
                        begin
                            pos_reg <= seg_end ? lo_first_reg : pos_reg + P_ONE;
                        end
                        else
                        begin
                            pos_reg <= pos_reg - P_ONE;
                        end
                    end
                end
            end
        endcase
        if (emit)
        begin
            pixel_reg.pixel_index <= idx_wide[INDEX_W-1:0];
            pixel_reg.red         <= color.red;
            pixel_reg.green       <= color.green;
            pixel_reg.blue        <= color.blue;
            pixel_reg.last        <= emit_last;
        end
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel       = pixel_reg;
    assign status.busy = (state_reg != BK_IDLE);

endmodule

// File: hw/rtl/led_bar_level_meter.sv
// LED bar level meter. Sample transactions (operation 0) keep, per band, the peak of
// |sample-2048| and are taken whenever offered. An update transaction (operation 1)
// is queued in a two-entry queue; the back end takes it from the queue, then computes
// the new level (two constant products, the gain multiply, clamp, range planning) and
// after that makes one pixel write per cycle while the output is not stalled. Pixels
// past either strip end are skipped, so an update writes at most 32 pixels at the
// default sizes (16 positions on each of the band's two strips).
// Sample transactions keep flowing while the back end works; update transactions stall
// only when the queue is full.
// The gain register is written through cfg_we/cfg_wdata and should change only when
// the block is idle.
module led_bar_level_meter #(
    parameter int BANDS     = 7,
    parameter int STRIP_LEN = 16,
    parameter int CENTER    = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lbm_pkg::GAIN_W-1:0]  cfg_wdata,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  lbm_pkg::item_t              item,
    output logic                        pixel_valid,
    input  logic                        pixel_ready,
    output lbm_pkg::pixel_t             pixel
);
    import lbm_pkg::*;

    logic          q_push;
    logic          q_pop;
    q_entry_t      q_wdata;
    q_entry_t      q_rdata;
    fifo_status_t  q_stat;
    back_status_t  back_stat;

    lbm_front #(
        .BANDS(BANDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_push     (q_push),
        .q_entry    (q_wdata),
        .q_full     (q_stat.full)
    );

    lbm_fifo #(
        .DEPTH(2)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_stat)
    );

    lbm_back #(
        .BANDS     (BANDS),
        .STRIP_LEN (STRIP_LEN),
        .CENTER    (CENTER)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_entry     (q_rdata),
        .q_status    (q_stat),
        .q_pop       (q_pop),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .status      (back_stat)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("update queued while queue full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    a_pop_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> back_stat.busy)
        else $error("back end idle after taking an update");

    a_more_pixels_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel_ready && !pixel.last) |-> back_stat.busy)
        else $error("non-final pixel transaction with back end idle");

endmodule

// File: dv/tb_led_bar_level_meter.sv
`timescale 1ns / 100ps

module tb_led_bar_level_meter;

    import lbm_pkg::*;

    localparam int BANDS          = 7;
    localparam int STRIP_LEN      = 16;
    localparam int CENTER         = 8;
    localparam int SPAN           = STRIP_LEN - CENTER;
    localparam int TARGET_ITEMS   = 470;
    localparam int PHASE_ITEMS    = 80;
    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                cfg_we      = 1'b0;
    logic [GAIN_W-1:0]   cfg_wdata   = '0;
    logic                item_valid  = 1'b0;
    logic                item_ready;
    item_t               item        = '0;
    logic                pixel_valid;
    logic                pixel_ready = 1'b0;
    pixel_t              pixel;

    // strip colors, full brightness
    logic [7:0] strip_red   [14] = '{255, 200, 145, 90, 35, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    logic [7:0] strip_green [14] = '{0, 0, 0, 0, 0, 0, 35, 70, 105, 140, 175, 210, 245, 255};
    logic [7:0] strip_blue  [14] = '{0, 55, 110, 165, 220, 255, 220, 185, 150, 115, 80, 45, 10, 0};

    // predictor state
    logic [GAIN_W-1:0] gain_now = GAIN_RESET;
    logic [PEAK_W-1:0] peak_hold [BANDS];
    logic [4:0]        bar_now   [BANDS];

    item_t  item_backlog [$];
    pixel_t pixel_writes_due [$];

    int  mismatch_count = 0;
    int  items_queued   = 0;
    int  gap_left       = 0;
    int  hold_left      = 0;
    int  quiet_cycles   = 0;
    bit  item_taken     = 1'b0;
    bit  idle_en        = 1'b1;

    led_bar_level_meter #(
        .BANDS     (BANDS),
        .STRIP_LEN (STRIP_LEN),
        .CENTER    (CENTER)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        for (int b = 0; b < BANDS; b++)
        begin
            peak_hold[b] = '0;
            bar_now[b]   = '0;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void queue_strip_pixel(int strip, int pos, bit lit);
        pixel_t px;
        if (pos < 0 || pos >= STRIP_LEN)
            return;
        px = '0;
        px.pixel_index = 8'(strip * STRIP_LEN + pos);
        if (lit)
        begin
            if (strip < 14)
            begin
                px.red   = strip_red[strip];
                px.green = strip_green[strip];
                px.blue  = strip_blue[strip];
            end
            else
                px.red = 8'd255;
            // lower side is drawn at a tenth of the brightness
            if (pos < CENTER)
            begin
                px.red   = px.red / 8'd10;
                px.green = px.green / 8'd10;
                px.blue  = px.blue / 8'd10;
            end
        end
        pixel_writes_due.push_back(px);
    endfunction

    function automatic void queue_band_pair(int band, int pos, bit lit);
        queue_strip_pixel(2 * band, pos, lit);
        queue_strip_pixel(2 * band + 1, pos, lit);
    endfunction

    function automatic void predict_meter_item(item_t it);
        int                unsigned b;
        logic [PEAK_W-1:0] mag;
        longint unsigned   acc;
        int                old_lvl;
        int                new_lvl;
        int                n_before;
        pixel_t            tail;
        b = it.band;
        if (b >= BANDS)
            return;
        if (it.operation == OP_SAMPLE)
        begin
            mag = (it.sample >= MID_SCALE) ? it.sample - MID_SCALE : MID_SCALE - it.sample;
            if (mag > peak_hold[b])
                peak_hold[b] = mag;
            return;
        end
        old_lvl = bar_now[b];
        acc = 64'd364 * peak_hold[b] * SPAN + 64'd323584 * old_lvl;
        acc = (acc * gain_now) >> 28;
        if (acc > SPAN)
            acc = SPAN;
        new_lvl = int'(acc);
        bar_now[b]   = 5'(new_lvl);
        peak_hold[b] = '0;
        n_before = pixel_writes_due.size();
        if (new_lvl > old_lvl)
        begin
            for (int p = CENTER + old_lvl; p <= CENTER + new_lvl; p++)
                queue_band_pair(b, p, 1'b1);
            for (int p = CENTER - old_lvl - 1; p >= CENTER - new_lvl - 1; p--)
                queue_band_pair(b, p, 1'b1);
        end
        else
        begin
            for (int p = CENTER + new_lvl + 1; p <= CENTER + old_lvl; p++)
                queue_band_pair(b, p, 1'b0);
            for (int p = CENTER - new_lvl - 2; p >= CENTER - old_lvl - 1; p--)
                queue_band_pair(b, p, 1'b0);
        end
        if (pixel_writes_due.size() > n_before)
        begin
            tail = pixel_writes_due.pop_back();
            tail.last = 1'b1;
            pixel_writes_due.push_back(tail);
        end
    endfunction

    task automatic note_mismatch(string what, pixel_t exp_px, pixel_t got_px);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s: expected idx %0d rgb %0d/%0d/%0d last %0b, got idx %0d rgb %0d/%0d/%0d last %0b",
                     what, exp_px.pixel_index, exp_px.red, exp_px.green, exp_px.blue,
                     exp_px.last, got_px.pixel_index, got_px.red, got_px.green,
                     got_px.blue, got_px.last);
    endtask

    // item driver
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_taken))
        begin
            item_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (item_backlog.size() > 0)
            begin
                item       <= item_backlog.pop_front();
                item_valid <= 1'b1;
                gap_left = (idle_en && $urandom_range(0, 1)) ? pick_gap() : 0;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // pixel receiver back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                pixel_ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 4) == 0)
            begin
                hold_left = pick_gap() - 1;
                pixel_ready <= 1'b0;
            end
            else
                pixel_ready <= 1'b1;
        end
    end

    // monitor: check pixel writes, then predict from the accepted item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                gain_now = cfg_wdata;
            if (pixel_valid && pixel_ready)
            begin
                if (pixel_writes_due.size() == 0)
                    note_mismatch("unexpected pixel write", '0, pixel);
                else
                begin
                    pixel_t due;
                    due = pixel_writes_due.pop_front();
                    if (pixel.pixel_index !== due.pixel_index || pixel.red !== due.red ||
                        pixel.green !== due.green || pixel.blue !== due.blue ||
                        pixel.last !== due.last)
                        note_mismatch("pixel write mismatch", due, pixel);
                end
            end
            if (item_valid && item_ready)
            begin
                predict_meter_item(item);
                item_taken = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !(item_valid && item_ready) && !(pixel_valid && pixel_ready))
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
        else
            quiet_cycles = 0;
    end

    task automatic queue_item(op_t op, int band, int sample);
        item_t it;
        it.operation = op;
        it.band      = 3'(band);
        it.sample    = 12'(sample);
        item_backlog.push_back(it);
        if (band < BANDS)
            items_queued++;
    endtask

    function automatic int pick_sample(int amp);
        int v;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? 0 : 4095;
        v = 2048 + int'($urandom_range(0, 2 * amp)) - amp;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v;
    endfunction

    // samples for one band closed by its update
    task automatic queue_band_sweep(int band);
        int n_samples;
        int amp;
        n_samples = $urandom_range(0, 5);
        amp = $urandom_range(0, 3) == 0 ? 2048 : $urandom_range(0, 1400);
        repeat (n_samples)
            queue_item(OP_SAMPLE, band, pick_sample(amp));
        queue_item(OP_UPDATE, band, $urandom_range(0, 4095));
    endtask

    task automatic drain_and_settle();
        while (item_backlog.size() != 0 || item_valid || pixel_writes_due.size() != 0)
            @(posedge clk);
        // an update that draws nothing may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_gain(logic [GAIN_W-1:0] value);
        @(negedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int phase;
        int phase_start;
        logic [GAIN_W-1:0] phase_gain;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset gain: grow, shrink, decay to zero, then an update with no change
        queue_item(OP_SAMPLE, 0, 0);
        queue_item(OP_UPDATE, 0, 0);
        queue_item(OP_SAMPLE, 0, 2048);
        queue_item(OP_UPDATE, 0, 4095);
        queue_item(OP_UPDATE, 0, 0);
        queue_item(OP_UPDATE, 0, 0);
        // band past the last one is dropped
        queue_item(OP_SAMPLE, 7, 0);
        queue_item(OP_UPDATE, 7, 0);
        queue_item(OP_SAMPLE, 6, 4095);
        queue_item(OP_SAMPLE, 6, 2047);
        queue_item(OP_UPDATE, 6, 2048);
        queue_item(OP_SAMPLE, 1, 2049);
        queue_item(OP_SAMPLE, 1, 2047);
        queue_item(OP_UPDATE, 1, 1);
        drain_and_settle();

        // top gain: full bar clipped at both strip ends, then a saturated no-change
        write_gain(12'd4095);
        queue_item(OP_SAMPLE, 3, 0);
        queue_item(OP_UPDATE, 3, 0);
        queue_item(OP_UPDATE, 3, 0);
        queue_item(OP_SAMPLE, 5, 2049);
        queue_item(OP_UPDATE, 5, 0);
        drain_and_settle();

        // zero gain: every bar collapses
        write_gain(12'd0);
        queue_item(OP_UPDATE, 3, 0);
        queue_item(OP_UPDATE, 6, 0);
        queue_item(OP_UPDATE, 5, 0);
        drain_and_settle();

        phase = 0;
        while (items_queued < TARGET_ITEMS)
        begin
            case (phase % 6)
                0:       phase_gain = 12'($urandom_range(0, 4095));
                1:       phase_gain = 12'd4095;
                2:       phase_gain = 12'($urandom_range(200, 800));
                3:       phase_gain = 12'd0;
                4:       phase_gain = GAIN_RESET;
                default: phase_gain = 12'($urandom_range(800, 2000));
            endcase
            idle_en = (phase % 6 != 2);
            write_gain(phase_gain);
            phase_start = items_queued;
            while (items_queued - phase_start < PHASE_ITEMS && items_queued < TARGET_ITEMS)
            begin
                if ($urandom_range(0, 4) != 0)
                    queue_band_sweep($urandom_range(0, BANDS - 1));
                else
                    queue_item(op_t'($urandom_range(0, 1)), $urandom_range(0, 7),
                               $urandom_range(0, 4095));
            end
            drain_and_settle();
            phase++;
        end
        idle_en = 1'b1;

        while (pixel_writes_due.size() != 0)
            note_mismatch("missing pixel write", pixel_writes_due.pop_front(), '0);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
